### rtl/core/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operand and result words, operation codes, and the word that walks down
// the divider pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int IN_W       = 16;                 // operand part width
   localparam int FRAC_BITS  = 8;                  // fraction bits of all values
   localparam int OUT_W      = 32;                 // result part width
   localparam int PROD_W     = 2 * IN_W;           // one exact product
   localparam int SUM_W      = PROD_W + 2;         // sum of two products
   localparam int MAG_W      = SUM_W;              // magnitude of such a sum
   localparam int DEN_W      = PROD_W;             // |b|^2, never above 2^(2*IN_W-1)
   localparam int QUO_W      = PROD_W + FRAC_BITS; // dividend and quotient width
   localparam int DIV_BPS    = 2;                  // quotient bits per divider stage
   localparam int DIV_STAGES = (QUO_W + DIV_BPS - 1) / DIV_BPS;
   localparam int FRONT_STAGES = 3;
   localparam int LATENCY    = FRONT_STAGES + DIV_STAGES + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef logic signed [IN_W-1:0]    part_type;
   typedef logic signed [IN_W:0]      addsub_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic        [MAG_W-1:0]   mag_type;
   typedef logic        [DEN_W-1:0]   den_type;
   typedef logic        [QUO_W-1:0]   quo_type;
   typedef logic signed [OUT_W-1:0]   res_type;

   typedef struct packed {
      op_type   operation;
      part_type a_re;
      part_type a_im;
      part_type b_re;
      part_type b_im;
   } req_type;

   typedef struct packed {
      res_type res_re;
      res_type res_im;
      logic    div_by_zero;
      logic    overflow;
   } rsp_type;

   // One lane of the restoring divider: partial remainder and a shift
   // register that gives up dividend bits at the top and takes quotient
   // bits at the bottom. For other operations q simply holds the magnitude.
   typedef struct packed {
      den_type rem;
      quo_type q;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      logic         is_div;
      logic         dz;
      logic         neg_re;
      logic         neg_im;
      den_type      den;
      div_lane_type lane_re;
      div_lane_type lane_im;
   } div_pipe_type;

   localparam quo_type SAT_POS_MAG = quo_type'(32'h7FFF_FFFF);
   localparam quo_type SAT_NEG_MAG = quo_type'(32'h8000_0000);
   localparam res_type SAT_POS     = 32'sh7FFF_FFFF;
   localparam res_type SAT_NEG     = -32'sh7FFF_FFFF - 32'sh1;

   // DIV_BPS restoring division steps on one lane.
   function automatic div_lane_type div_steps(div_lane_type x, den_type den);
      logic [DEN_W:0] trial;
      div_lane_type   r;
      r = x;
      for (int i = 0; i < DIV_BPS; i++) begin
         trial = {r.rem, r.q[QUO_W-1]};
         r.q   = {r.q[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial  = trial - {1'b0, den};
            r.q[0] = 1'b1;
         end
         r.rem = trial[DEN_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: products, sums and sign-magnitude conversion
// Three register stages: exact products and squares, the operation's sums
// and |b|^2, then magnitudes scaled for the divider or the multiply result.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cau_pkg::req_type      in_data,
   output cau_pkg::div_pipe_type pipe_out
);

   // stage A: products
   logic                 a_vld_ff;
   cau_pkg::op_type      a_op_ff;
   logic                 a_dz_ff;
   cau_pkg::prod_type    a_rr_ff, a_ii_ff, a_ri_ff, a_ir_ff, a_sqr_ff, a_sqi_ff;
   cau_pkg::addsub_type  a_sre_ff, a_sim_ff;
   cau_pkg::addsub_type  a_sre_in, a_sim_in;

   // stage B: sums
   logic                 b_vld_ff;
   cau_pkg::op_type      b_op_ff;
   logic                 b_dz_ff;
   cau_pkg::sum_type     b_re_ff, b_im_ff, b_re_in, b_im_in;
   cau_pkg::den_type     b_den_ff;

   // stage C: magnitudes
   logic                 c_vld_ff;
   cau_pkg::div_pipe_type c_data_ff, c_data_in;
   cau_pkg::mag_type     mag_re, mag_im;

   always_comb begin
      if (in_data.operation == cau_pkg::OP_SUB) begin
         a_sre_in = cau_pkg::addsub_type'(in_data.a_re) - cau_pkg::addsub_type'(in_data.b_re);
         a_sim_in = cau_pkg::addsub_type'(in_data.a_im) - cau_pkg::addsub_type'(in_data.b_im);
      end else begin
         a_sre_in = cau_pkg::addsub_type'(in_data.a_re) + cau_pkg::addsub_type'(in_data.b_re);
         a_sim_in = cau_pkg::addsub_type'(in_data.a_im) + cau_pkg::addsub_type'(in_data.b_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff  <= in_data.operation;
      a_dz_ff  <= (in_data.b_re == '0) && (in_data.b_im == '0);
      a_rr_ff  <= in_data.a_re * in_data.b_re;
      a_ii_ff  <= in_data.a_im * in_data.b_im;
      a_ri_ff  <= in_data.a_re * in_data.b_im;
      a_ir_ff  <= in_data.a_im * in_data.b_re;
      a_sqr_ff <= in_data.b_re * in_data.b_re;
      a_sqi_ff <= in_data.b_im * in_data.b_im;
      a_sre_ff <= a_sre_in;
      a_sim_ff <= a_sim_in;
   end

   always_comb begin
      case (a_op_ff)
         cau_pkg::OP_MUL: begin
            b_re_in = cau_pkg::sum_type'(a_rr_ff) - cau_pkg::sum_type'(a_ii_ff);
            b_im_in = cau_pkg::sum_type'(a_ri_ff) + cau_pkg::sum_type'(a_ir_ff);
         end
         cau_pkg::OP_DIV: begin
            b_re_in = cau_pkg::sum_type'(a_rr_ff) + cau_pkg::sum_type'(a_ii_ff);
            b_im_in = cau_pkg::sum_type'(a_ir_ff) - cau_pkg::sum_type'(a_ri_ff);
         end
         default: begin
            b_re_in = cau_pkg::sum_type'(a_sre_ff);
            b_im_in = cau_pkg::sum_type'(a_sim_ff);
         end
      endcase
   end

   // Squares are never negative and their sum never exceeds 2^(2*IN_W-1).
   always_ff @(posedge clock) begin
      b_op_ff  <= a_op_ff;
      b_dz_ff  <= a_dz_ff;
      b_re_ff  <= b_re_in;
      b_im_ff  <= b_im_in;
      b_den_ff <= cau_pkg::den_type'(a_sqr_ff) + cau_pkg::den_type'(a_sqi_ff);
   end

   always_comb begin
      mag_re = b_re_ff[cau_pkg::SUM_W-1] ? cau_pkg::mag_type'(-b_re_ff)
                                         : cau_pkg::mag_type'(b_re_ff);
      mag_im = b_im_ff[cau_pkg::SUM_W-1] ? cau_pkg::mag_type'(-b_im_ff)
                                         : cau_pkg::mag_type'(b_im_ff);
      c_data_in             = '0;
      c_data_in.is_div      = (b_op_ff == cau_pkg::OP_DIV);
      c_data_in.dz          = b_dz_ff && (b_op_ff == cau_pkg::OP_DIV);
      c_data_in.neg_re      = b_re_ff[cau_pkg::SUM_W-1];
      c_data_in.neg_im      = b_im_ff[cau_pkg::SUM_W-1];
      c_data_in.den         = b_den_ff;
      case (b_op_ff)
         cau_pkg::OP_MUL: begin
            c_data_in.lane_re.q = cau_pkg::quo_type'(mag_re) >> cau_pkg::FRAC_BITS;
            c_data_in.lane_im.q = cau_pkg::quo_type'(mag_im) >> cau_pkg::FRAC_BITS;
         end
         cau_pkg::OP_DIV: begin
            // The dividend carries the fraction bits of the quotient.
            c_data_in.lane_re.q = cau_pkg::quo_type'(mag_re) << cau_pkg::FRAC_BITS;
            c_data_in.lane_im.q = cau_pkg::quo_type'(mag_im) << cau_pkg::FRAC_BITS;
         end
         default: begin
            c_data_in.lane_re.q = cau_pkg::quo_type'(mag_re);
            c_data_in.lane_im.q = cau_pkg::quo_type'(mag_im);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      c_data_ff <= c_data_in;
   end

   always_comb begin
      pipe_out       = c_data_ff;
      pipe_out.valid = c_vld_ff;
   end

endmodule

### rtl/core/cau_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_stage: one stage of the pipelined restoring divider
// Works a few quotient bits on both lanes against the shared |b|^2;
// words of other operations pass through unchanged.
// ----------------------------------------------------------------------------
module cau_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  cau_pkg::div_pipe_type pipe_in,
   output cau_pkg::div_pipe_type pipe_out
);

   logic                  valid_ff;
   cau_pkg::div_pipe_type data_ff, data_in;

   always_comb begin
      data_in = pipe_in;
      if (pipe_in.is_div) begin
         data_in.lane_re = cau_pkg::div_steps(pipe_in.lane_re, pipe_in.den);
         data_in.lane_im = cau_pkg::div_steps(pipe_in.lane_im, pipe_in.den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pipe_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      pipe_out       = data_ff;
      pipe_out.valid = valid_ff;
   end

endmodule

### rtl/core/cau_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_sat: sign restore and 32-bit saturation
// Turns sign and magnitude back into two's complement, clamps, and raises
// the overflow and divide-by-zero flags in the result register.
// ----------------------------------------------------------------------------
module cau_sat (
   input  logic                  clock,
   input  logic                  reset,
   input  cau_pkg::div_pipe_type pipe_in,
   output logic                  out_valid,
   output cau_pkg::rsp_type      out_data
);

   logic             valid_ff;
   cau_pkg::rsp_type data_ff, data_in;
   logic             sat_re, sat_im;

   function automatic cau_pkg::res_type to_res(logic neg, cau_pkg::quo_type mag,
                                                output logic sat);
      cau_pkg::res_type r;
      sat = 1'b0;
      // A negative sign with zero magnitude is plain zero.
      if (!neg || mag == '0) begin
         if (mag > cau_pkg::SAT_POS_MAG) begin
            sat = 1'b1;
            r   = cau_pkg::SAT_POS;
         end else begin
            r = cau_pkg::res_type'(mag[cau_pkg::OUT_W-1:0]);
         end
      end else begin
         if (mag > cau_pkg::SAT_NEG_MAG) begin
            sat = 1'b1;
            r   = cau_pkg::SAT_NEG;
         end else begin
            r = cau_pkg::res_type'(-mag[cau_pkg::OUT_W-1:0]);
         end
      end
      return r;
   endfunction

   always_comb begin
      data_in.res_re = to_res(pipe_in.neg_re, pipe_in.lane_re.q, sat_re);
      data_in.res_im = to_res(pipe_in.neg_im, pipe_in.lane_im.q, sat_im);
      data_in.div_by_zero = pipe_in.dz;
      data_in.overflow    = (sat_re || sat_im) && !pipe_in.dz;
      if (pipe_in.dz) begin
         data_in.res_re = '0;
         data_in.res_im = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pipe_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add, subtract, multiply, divide
// Q7.8 operands in, saturated Q23.8 results out, one word per cycle while busy is low.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start is high, busy low
//   response  rsp_strobe, rsp_data       one cycle per word, cannot stall
//
// Every word passes 24 registers: three front stages (products, sums,
// magnitudes), 20 divider stages at two quotient bits each, and the
// saturation register. All operations share that path, so words leave
// in order. A new word may enter every cycle while busy is low. Busy is
// high during reset and in the cycle after it; synchronous reset empties
// the pipeline.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cau_pkg::req_type req_data,
   output logic             rsp_strobe,
   output cau_pkg::rsp_type rsp_data
);

   logic                  busy_ff;
   logic                  accept;
   cau_pkg::div_pipe_type pipe [0:cau_pkg::DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .pipe_out (pipe[0])
   );

   for (genvar s = 0; s < cau_pkg::DIV_STAGES; s++) begin : g_div
      cau_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .pipe_in  (pipe[s]),
         .pipe_out (pipe[s+1])
      );
   end

   cau_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .pipe_in   (pipe[cau_pkg::DIV_STAGES]),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(cau_pkg::LATENCY) rsp_strobe)
      else $error("accepted word did not leave after the pipeline latency");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, cau_pkg::LATENCY))
      else $error("response strobe without a matching request");

   a_dz_only_div : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation != cau_pkg::OP_DIV)
      |-> ##(cau_pkg::LATENCY) !rsp_data.div_by_zero)
      else $error("divide-by-zero flag on a non-divide word");

   a_dz_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.div_by_zero)
      |-> (!rsp_data.overflow && rsp_data.res_re == '0 && rsp_data.res_im == '0))
      else $error("divide-by-zero word with nonzero result or overflow");
`endif

endmodule
